[hw/rtl/sawbc_pkg.sv]
// shared constants and the controller state type of the cache tag store
// no dependencies
`timescale 1ns / 1ps

package sawbc_pkg;

  localparam int ADDR_W     = 32;
  localparam int WAYS_REG_W = 3;
  localparam int OUT_WAY_W  = 2;

  localparam logic [WAYS_REG_W-1:0] WAYS_RESET = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

endpackage

[hw/rtl/sawbc_lookup.sv]
// tag compare, victim choice and row update for one set of the tag store
// depends on sawbc_pkg
`timescale 1ns / 1ps

module sawbc_lookup
  import sawbc_pkg::*;
#(
  parameter int TAG_W = 21,
  parameter int WAYS  = 4,
  parameter int WAY_W = 2,
  parameter int CNT_W = 3
) (
  input  logic [WAYS_REG_W-1:0]      ways_cfg,
  input  logic                       cmd,
  input  logic [TAG_W-1:0]           tag,
  input  logic [WAYS-1:0][TAG_W-1:0] rd_tag,
  input  logic [WAYS-1:0]            rd_vld,
  input  logic [WAYS-1:0]            rd_dty,
  input  logic [WAY_W-1:0]           rd_vic,
  output logic                       hit,
  output logic                       evict,
  output logic [WAY_W-1:0]           way,
  output logic [WAY_W-1:0]           next_vic,
  output logic [WAYS-1:0][TAG_W-1:0] wr_tag,
  output logic [WAYS-1:0]            wr_vld,
  output logic [WAYS-1:0]            wr_dty
);

  logic [CNT_W-1:0] n;
  logic [WAYS-1:0]  match;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] victim;

  // effective way count: zero acts as one, clamp at WAYS
  always_comb begin
    if (ways_cfg == '0) begin
      n = CNT_W'(1);
    end else if (int'(ways_cfg) > WAYS) begin
      n = CNT_W'(WAYS);
    end else begin
      n = CNT_W'(ways_cfg);
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (w < int'(n)) && rd_vld[w] && (rd_tag[w] == tag);
    end
  end

  // lowest matching way wins
  always_comb begin
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
    end
  end

  assign hit = |match;

  // stale pointer after the way count was lowered falls back to way 0
  assign victim = (int'(rd_vic) >= int'(n)) ? '0 : rd_vic;
  assign way    = hit ? hit_way : victim;
  assign evict  = !hit && rd_vld[victim] && rd_dty[victim];

  assign next_vic = (int'(way) + 1 == int'(n)) ? '0 : WAY_W'(int'(way) + 1);

  always_comb begin
    wr_tag = rd_tag;
    wr_vld = rd_vld;
    wr_dty = rd_dty;
    if (hit) begin
      if (cmd) begin
        wr_dty[hit_way] = 1'b1;
      end
    end else begin
      wr_tag[victim] = tag;
      wr_vld[victim] = 1'b1;
      wr_dty[victim] = cmd;
    end
  end

endmodule

[hw/rtl/set_assoc_writeback_cache_tags.sv]
// channel   direction  handshake           payload
// cfg       in         cfg_we              cfg_wdata (ways in use)
// in        in         in_valid/in_ready   in_cmd, in_address
// out       out        out_valid/out_ready out_hit, out_dirty_evict, out_way_used
//
// each access reads the set's row from the row memory on the accept edge; the
// lookup state then compares tags and writes the updated row back.
// after reset a clearing pass over every set zeroes valid, dirty and
// victim state; no transaction is accepted until it ends.
// a result held in the output register stalls the lookup cycle until taken.
// depends on sawbc_pkg and sawbc_lookup
`timescale 1ns / 1ps

module set_assoc_writeback_cache_tags
  import sawbc_pkg::*;
#(
  parameter int OFFSET_BITS = 5,
  parameter int INDEX_BITS  = 6,
  parameter int WAYS        = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [WAYS_REG_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [ADDR_W-1:0]     in_address,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic                  out_dirty_evict,
  output logic [OUT_WAY_W-1:0]  out_way_used
);

  localparam int TAG_W = ADDR_W - OFFSET_BITS - INDEX_BITS;
  localparam int IDX_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
  localparam int SETS  = 1 << INDEX_BITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CNT_W = $clog2(WAYS + 1);
  localparam logic [IDX_W-1:0] SET_MASK = IDX_W'((64'd1 << INDEX_BITS) - 64'd1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]      clr_idx_r;
  logic [WAYS_REG_W-1:0] ways_r;

  logic                  cmd_r;
  logic [TAG_W-1:0]      tag_r;
  logic [IDX_W-1:0]      set_r;

  logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
  logic [WAYS-1:0]            vld_mem [SETS];
  logic [WAYS-1:0]            dty_mem [SETS];
  logic [WAY_W-1:0]           vic_mem [SETS];

  logic [WAYS-1:0][TAG_W-1:0] rd_tag_r;
  logic [WAYS-1:0]            rd_vld_r;
  logic [WAYS-1:0]            rd_dty_r;
  logic [WAY_W-1:0]           rd_vic_r;

  logic                       lk_hit, lk_evict;
  logic [WAY_W-1:0]           lk_way, lk_next_vic;
  logic [WAYS-1:0][TAG_W-1:0] lk_tag;
  logic [WAYS-1:0]            lk_vld, lk_dty;

  logic                  out_valid_r, out_hit_r, out_evict_r;
  logic [OUT_WAY_W-1:0]  out_way_r;

  logic [ADDR_W-1:0] addr_sh;
  logic [IDX_W-1:0]  in_set;
  logic [TAG_W-1:0]  in_tag;
  logic              acc;
  logic              out_free;
  logic              look_done;
  logic              clearing;
  logic [IDX_W-1:0]  wr_set;

  assign addr_sh = in_address >> OFFSET_BITS;
  assign in_set  = addr_sh[IDX_W-1:0] & SET_MASK;
  assign in_tag  = TAG_W'(in_address >> (OFFSET_BITS + INDEX_BITS));

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign look_done = (state_r == S_LOOK) && out_free;
  assign clearing  = (state_r == S_CLEAR);
  assign wr_set    = clearing ? clr_idx_r : set_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_idx_r == SET_MASK) state_nxt = S_IDLE;
      S_IDLE:  if (acc) state_nxt = S_LOOK;
      S_LOOK:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      ways_r    <= WAYS_RESET;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (cfg_we) begin
        ways_r <= cfg_wdata;
      end
    end
  end

  // access registers, loaded with the transaction
  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= in_cmd;
      tag_r <= in_tag;
      set_r <= in_set;
    end
  end

  // row memory: one read on accept, one write on lookup or clearing
  always_ff @(posedge clk) begin
    if (look_done) begin
      tag_mem[wr_set] <= lk_tag;
    end
    if (look_done || clearing) begin
      vld_mem[wr_set] <= clearing ? '0 : lk_vld;
      dty_mem[wr_set] <= clearing ? '0 : lk_dty;
      vic_mem[wr_set] <= clearing ? '0 : lk_next_vic;
    end
    if (acc) begin
      rd_tag_r <= tag_mem[in_set];
      rd_vld_r <= vld_mem[in_set];
      rd_dty_r <= dty_mem[in_set];
      rd_vic_r <= vic_mem[in_set];
    end
  end

  sawbc_lookup #(
    .TAG_W (TAG_W),
    .WAYS  (WAYS),
    .WAY_W (WAY_W),
    .CNT_W (CNT_W)
  ) u_lookup (
    .ways_cfg (ways_r),
    .cmd      (cmd_r),
    .tag      (tag_r),
    .rd_tag   (rd_tag_r),
    .rd_vld   (rd_vld_r),
    .rd_dty   (rd_dty_r),
    .rd_vic   (rd_vic_r),
    .hit      (lk_hit),
    .evict    (lk_evict),
    .way      (lk_way),
    .next_vic (lk_next_vic),
    .wr_tag   (lk_tag),
    .wr_vld   (lk_vld),
    .wr_dty   (lk_dty)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (look_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_done) begin
      out_hit_r   <= lk_hit;
      out_evict_r <= lk_evict;
      out_way_r   <= OUT_WAY_W'({{OUT_WAY_W{1'b0}}, lk_way});
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_dirty_evict = out_evict_r;
  assign out_way_used    = out_way_r;

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_dirty_evict)
    else $error("dirty evict reported on a hit");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> !in_ready)
    else $error("transaction accepted during clearing pass");

  a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_LOOK)
    else $error("accepted transaction did not enter lookup");

  a_look_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK && out_free |=> out_valid)
    else $error("lookup finished without a result");

endmodule
